// ===== src/pdfdate_pkg.sv =====
package pdfdate_pkg;

    // Character codes used by the classifier
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_ZULU    = 8'h5A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PREFIX  = 8'h44;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_APOS    = 8'h27;

    // Range limits
    localparam logic [6:0] MAX_MONTH  = 7'd12;
    localparam logic [6:0] MAX_DAY    = 7'd31;
    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MINUTE = 7'd59;

    // Zone kinds
    localparam logic [1:0] ZONE_NONE  = 2'd0;
    localparam logic [1:0] ZONE_UTC   = 2'd1;
    localparam logic [1:0] ZONE_PLUS  = 2'd2;
    localparam logic [1:0] ZONE_MINUS = 2'd3;

    localparam int RES_W   = 54;
    localparam int TDATA_W = 56;

    // Class of one input character
    typedef enum logic [3:0] {
        TK_DIGIT,
        TK_PREFIX,
        TK_COLON,
        TK_ZULU,
        TK_PLUS,
        TK_MINUS,
        TK_APOS,
        TK_OTHER,
        TK_END
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    // Write side of the token queue
    typedef struct packed {
        logic   push;
        token_t tok;
    } q_wr_t;

    // Result, last field (valid_res) in the lowest bits
    typedef struct packed {
        logic [5:0]  zone_minutes;
        logic [4:0]  zone_hours;
        logic [1:0]  zone_kind;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        valid_res;
    } result_t;

endpackage

// ===== src/pdfdate_front.sv =====
module pdfdate_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // char_code
    input  logic                s_axis_tlast,   // end_of_string
    input  logic                queue_full,
    output pdfdate_pkg::q_wr_t  q_wr
);
    import pdfdate_pkg::*;

    token_t tok;

    // Classify the incoming character
    always_comb begin
        tok.digit = s_axis_tdata[3:0];
        if (s_axis_tlast) begin
            tok.kind = TK_END;
        end else if (s_axis_tdata inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            tok.kind = TK_DIGIT;
        end else begin
            case (s_axis_tdata)
                CH_PREFIX: tok.kind = TK_PREFIX;
                CH_COLON:  tok.kind = TK_COLON;
                CH_ZULU:   tok.kind = TK_ZULU;
                CH_PLUS:   tok.kind = TK_PLUS;
                CH_MINUS:  tok.kind = TK_MINUS;
                CH_APOS:   tok.kind = TK_APOS;
                default:   tok.kind = TK_OTHER;
            endcase
        end
    end

    // Push into the queue whenever there is room
    assign s_axis_tready = !queue_full;
    assign q_wr.push     = s_axis_tvalid && !queue_full;
    assign q_wr.tok      = tok;

endmodule

// ===== src/pdfdate_fifo.sv =====
module pdfdate_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pdfdate_pkg::q_wr_t   q_wr,
    output logic                 full,
    output logic                 empty,
    output pdfdate_pkg::token_t  rd_tok,
    input  logic                 pop
);
    import pdfdate_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    token_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = q_wr.push && !full;
    assign do_pop  = pop && !empty;
    assign rd_tok  = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_wr.tok;
        end
    end

endmodule

// ===== src/pdfdate_back.sv =====
module pdfdate_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_empty,
    input  pdfdate_pkg::token_t                q_tok,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pdfdate_pkg::TDATA_W-1:0]    m_axis_tdata   // valid_res, year, month, day,
                                                              // hour, minute, second,
                                                              // zone_kind, zone_hours,
                                                              // zone_minutes
);
    import pdfdate_pkg::*;

    // Parse positions
    localparam logic [4:0] POS_START    = 5'd0;
    localparam logic [4:0] POS_COLON    = 5'd1;
    localparam logic [4:0] POS_YEAR0    = 5'd2;
    localparam logic [4:0] POS_YEAR1    = 5'd3;
    localparam logic [4:0] POS_YEAR2    = 5'd4;
    localparam logic [4:0] POS_YEAR3    = 5'd5;
    localparam logic [4:0] POS_MON_HI   = 5'd6;
    localparam logic [4:0] POS_MON_LO   = 5'd7;
    localparam logic [4:0] POS_DAY_HI   = 5'd8;
    localparam logic [4:0] POS_DAY_LO   = 5'd9;
    localparam logic [4:0] POS_HOUR_HI  = 5'd10;
    localparam logic [4:0] POS_HOUR_LO  = 5'd11;
    localparam logic [4:0] POS_MIN_HI   = 5'd12;
    localparam logic [4:0] POS_MIN_LO   = 5'd13;
    localparam logic [4:0] POS_SEC_HI   = 5'd14;
    localparam logic [4:0] POS_SEC_LO   = 5'd15;
    localparam logic [4:0] POS_ZONE     = 5'd16;
    localparam logic [4:0] POS_ZULU     = 5'd17;
    localparam logic [4:0] POS_ZH1      = 5'd18;
    localparam logic [4:0] POS_ZH2      = 5'd19;
    localparam logic [4:0] POS_AFTER_ZH = 5'd20;
    localparam logic [4:0] POS_APOS1    = 5'd21;
    localparam logic [4:0] POS_ZM2      = 5'd22;
    localparam logic [4:0] POS_AFTER_ZM = 5'd23;
    localparam logic [4:0] POS_DONE     = 5'd24;

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] acc_reg, acc_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [1:0]  zone_reg, zone_next;
    logic [6:0]  ofs_h_reg, ofs_h_next;
    logic [6:0]  ofs_m_reg, ofs_m_next;
    logic        failed_reg, failed_next;
    logic        m_valid_reg, m_valid_next;
    result_t     res_reg, res_next;

    logic        is_end, out_free, is_dig, ok, good;
    logic [3:0]  d;
    logic [17:0] acc_x10;
    logic [13:0] year_acc;
    logic [6:0]  pair_val;

    assign is_end   = (q_tok.kind == TK_END);
    assign is_dig   = (q_tok.kind == TK_DIGIT);
    assign d        = q_tok.digit;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign q_pop    = !q_empty && (!is_end || out_free);

    // Multiply by ten as two shifts and an add
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign year_acc = 14'(acc_x10 + 18'(d));
    assign pair_val = {acc_reg[3:0], 3'b000} + {2'b00, acc_reg[3:0], 1'b0} + {3'b000, d};

    // Final check on the terminator
    always_comb begin
        good = !failed_reg &&
               (pos_reg inside {POS_MON_HI, POS_DAY_HI, POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI,
                                POS_ZONE, POS_ZULU, POS_AFTER_ZH, POS_APOS1, POS_AFTER_ZM,
                                POS_DONE}) &&
               (month_reg >= 7'd1) && (month_reg <= MAX_MONTH) &&
               (day_reg >= 7'd1) && (day_reg <= MAX_DAY) &&
               (hour_reg <= MAX_HOUR) && (minute_reg <= MAX_MINUTE) &&
               (second_reg <= MAX_MINUTE) && (ofs_h_reg <= MAX_HOUR) &&
               (ofs_m_reg <= MAX_MINUTE);
    end

    // Parser step and output register
    always_comb begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        zone_next    = zone_reg;
        ofs_h_next   = ofs_h_reg;
        ofs_m_next   = ofs_m_reg;
        failed_next  = failed_reg;
        res_next     = res_reg;
        m_valid_next = out_free ? 1'b0 : m_valid_reg;
        ok           = 1'b1;

        if (q_pop && is_end) begin
            // Emit the result and return to the start of a string
            m_valid_next = 1'b1;
            res_next     = '0;
            if (good) begin
                res_next.valid_res    = 1'b1;
                res_next.year         = year_reg;
                res_next.month        = month_reg[3:0];
                res_next.day          = day_reg[4:0];
                res_next.hour         = hour_reg[4:0];
                res_next.minute       = minute_reg[5:0];
                res_next.second       = second_reg[5:0];
                res_next.zone_kind    = zone_reg;
                res_next.zone_hours   = ofs_h_reg[4:0];
                res_next.zone_minutes = ofs_m_reg[5:0];
            end
            pos_next    = POS_START;
            acc_next    = '0;
            year_next   = '0;
            month_next  = 7'd1;
            day_next    = 7'd1;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            zone_next   = ZONE_NONE;
            ofs_h_next  = '0;
            ofs_m_next  = '0;
            failed_next = 1'b0;
        end else if (q_pop && !failed_reg) begin
            case (pos_reg)
                POS_START: begin
                    if (q_tok.kind == TK_PREFIX) begin
                        pos_next = POS_COLON;
                    end else if (is_dig) begin
                        acc_next = {10'd0, d};
                        pos_next = POS_YEAR1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_COLON: begin
                    if (q_tok.kind == TK_COLON) begin
                        acc_next = '0;
                        pos_next = POS_YEAR0;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_YEAR0, POS_YEAR1, POS_YEAR2, POS_YEAR3: begin
                    if (is_dig) begin
                        acc_next = (pos_reg == POS_YEAR0) ? {10'd0, d} : year_acc;
                        if (pos_reg == POS_YEAR3) begin
                            year_next = year_acc;
                            pos_next  = POS_MON_HI;
                        end else begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_MON_HI, POS_DAY_HI, POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI, POS_ZONE: begin
                    if (q_tok.kind == TK_ZULU) begin
                        zone_next = ZONE_UTC;
                        pos_next  = POS_ZULU;
                    end else if (q_tok.kind == TK_PLUS) begin
                        zone_next = ZONE_PLUS;
                        pos_next  = POS_ZH1;
                    end else if (q_tok.kind == TK_MINUS) begin
                        zone_next = ZONE_MINUS;
                        pos_next  = POS_ZH1;
                    end else if (is_dig && pos_reg != POS_ZONE) begin
                        acc_next = {10'd0, d};
                        pos_next = pos_reg + 5'd1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_MON_LO, POS_DAY_LO, POS_HOUR_LO, POS_MIN_LO, POS_SEC_LO: begin
                    if (is_dig) begin
                        pos_next = pos_reg + 5'd1;
                        case (pos_reg)
                            POS_MON_LO:  month_next  = pair_val;
                            POS_DAY_LO:  day_next    = pair_val;
                            POS_HOUR_LO: hour_next   = pair_val;
                            POS_MIN_LO:  minute_next = pair_val;
                            default:     second_next = pair_val;
                        endcase
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_ZH1, POS_APOS1: begin
                    if (is_dig) begin
                        acc_next = {10'd0, d};
                        pos_next = (pos_reg == POS_ZH1) ? POS_ZH2 : POS_ZM2;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_ZH2: begin
                    if (is_dig) begin
                        ofs_h_next = pair_val;
                        pos_next   = POS_AFTER_ZH;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_AFTER_ZH: begin
                    if (q_tok.kind == TK_APOS) begin
                        pos_next = POS_APOS1;
                    end else if (is_dig) begin
                        acc_next = {10'd0, d};
                        pos_next = POS_ZM2;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_ZM2: begin
                    if (is_dig) begin
                        ofs_m_next = pair_val;
                        pos_next   = POS_AFTER_ZM;
                    end else begin
                        ok = 1'b0;
                    end
                end
                POS_AFTER_ZM: begin
                    if (q_tok.kind == TK_APOS) begin
                        pos_next = POS_DONE;
                    end else begin
                        ok = 1'b0;
                    end
                end
                default: begin
                    // Anything after a finished zone fails the string
                    ok = 1'b0;
                end
            endcase
            if (!ok) begin
                failed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_START;
            acc_reg     <= '0;
            year_reg    <= '0;
            month_reg   <= 7'd1;
            day_reg     <= 7'd1;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            zone_reg    <= ZONE_NONE;
            ofs_h_reg   <= '0;
            ofs_m_reg   <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            zone_reg    <= zone_next;
            ofs_h_reg   <= ofs_h_next;
            ofs_m_reg   <= ofs_m_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - RES_W)'(0), res_reg};

endmodule

// ===== src/pdf_date_string_parser_top.sv =====
// Path: a terminator accepted at the input is written into the token queue, then popped by
// the parser once the output is free and registered; queued tokens ahead are parsed first.
// Throughput: one character per cycle; the token queue and the output register let the
// input keep flowing while a result waits to be taken. Each string gives one result.
// The input stalls only when the QUEUE_DEPTH-entry token queue is full.
// Reset: synchronous, active low; clears the queue, the parser state and the output valid.
module pdf_date_string_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // char_code
    input  logic                               s_axis_tlast,   // end_of_string
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pdfdate_pkg::TDATA_W-1:0]    m_axis_tdata    // valid_res, year, month, day,
                                                               // hour, minute, second,
                                                               // zone_kind, zone_hours,
                                                               // zone_minutes
);
    import pdfdate_pkg::*;

    q_wr_t  q_wr;
    token_t q_tok;
    logic   q_full, q_empty, q_pop;

    // Classifier
    pdfdate_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (q_full),
        .q_wr          (q_wr)
    );

    // Token queue
    pdfdate_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .full    (q_full),
        .empty   (q_empty),
        .rd_tok  (q_tok),
        .pop     (q_pop)
    );

    // Parser and result register
    pdfdate_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_tok         (q_tok),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== src/pdfdate_checker.sv =====
module pdfdate_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pdfdate_pkg::TDATA_W-1:0]   m_axis_tdata
);
    import pdfdate_pkg::*;

    // Result held until taken
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Invalid result carries only zeros
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("invalid result with nonzero fields");

    // Valid result has month and day in range
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[18:15] != 4'd0 && m_axis_tdata[18:15] <= 4'd12 &&
            m_axis_tdata[23:19] != 5'd0)
        else $error("valid result with month or day out of range");

endmodule

bind pdf_date_string_parser_top pdfdate_checker u_pdfdate_checker (.*);
